// ===== sv/nmru_victim_select_defines.svh =====
// assertion macros for the nmru victim select block
`ifndef NMRU_VICTIM_SELECT_DEFINES_SVH
`define NMRU_VICTIM_SELECT_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define NVS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nmru victim select check failed");

// next-cycle implication, checked on every clock outside reset
`define NVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nmru victim select check failed");

`endif

// ===== sv/nvs_pkg.sv =====
// shared types, codes and helpers for the nmru victim select block
`default_nettype none

package nvs_pkg;

  localparam int OP_W      = 2;
  localparam int SETIDX_W  = 6;
  localparam int WAYIDX_W  = 3;
  localparam int STAMP_W   = 32;
  localparam int LFSR_W    = 16;

  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [LFSR_W-1:0]  LFSR_TAPS    = 16'hB400;
  localparam logic [LFSR_W-1:0]  SEED_DEFAULT = 16'd1;
  localparam logic [STAMP_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [STAMP_W-1:0] COUNT_RESET  = 32'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SETIDX_W-1:0] set_index;
    logic [WAYIDX_W-1:0] way_index;
  } in_item_t;

  typedef struct packed {
    logic                is_victim;
    logic [WAYIDX_W-1:0] victim_way;
    logic                victim_was_invalid;
  } out_item_t;

  // work class handed from front to back
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_TOUCH,
    KIND_INSERT,
    KIND_INVAL,
    KIND_QUERY
  } kind_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] nxt;
    nxt = v >> 1;
    if (v[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

  // a zero seed would lock the generator
  function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
    return (s == '0) ? SEED_DEFAULT : s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/nvs_fifo.sv =====
// small synchronous fifo used between the block's stages
`default_nettype none

module nvs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/nvs_front.sv =====
// front end: accepts items, classifies them, stamps them and draws the random value
`default_nettype none

module nvs_front import nvs_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire in_item_t                                request,
  input  wire logic                                    push,
  output logic                                         full,
  input  wire logic                                    cfg_we,
  input  wire logic [LFSR_W-1:0]                       cfg_data,
  input  wire logic                                    mid_full,
  input  wire logic                                    clearing,
  output logic                                         mid_push,
  output kind_t                                        mid_kind,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0]  mid_set,
  output logic [$clog2(WAYS)-1:0]                      mid_way,
  output logic [STAMP_W-1:0]                           mid_stamp,
  output logic [LFSR_W-1:0]                            mid_rnd
);

  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_IN_N = 2 ** SETIDX_W;

  logic [STAMP_W-1:0] event_count;
  logic [LFSR_W-1:0]  pick_lfsr;
  logic               accept;
  logic               way_ok;
  kind_t              kind;
  logic [SET_W-1:0]   set_lut [SET_IN_N];

  // set index folded onto the configured number of sets
  for (genvar g = 0; g < SET_IN_N; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SETS);
  end

  assign full   = mid_full | clearing;
  assign accept = push & ~full;
  assign way_ok = (int'(request.way_index) < WAYS);

  always_comb begin
    case (request.op)
      OP_TOUCH:  kind = way_ok ? KIND_TOUCH  : KIND_NOP;
      OP_INSERT: kind = way_ok ? KIND_INSERT : KIND_NOP;
      OP_INVAL:  kind = way_ok ? KIND_INVAL  : KIND_NOP;
      OP_QUERY:  kind = KIND_QUERY;
      default:   kind = KIND_NOP;
    endcase
  end

  assign mid_push  = accept;
  assign mid_kind  = kind;
  assign mid_set   = set_lut[request.set_index];
  assign mid_way   = WAY_W'(request.way_index);
  assign mid_stamp = event_count;
  assign mid_rnd   = pick_lfsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= COUNT_RESET;
      pick_lfsr   <= SEED_DEFAULT;
    end else begin
      if (cfg_we) begin
        pick_lfsr <= seed_fix(cfg_data);
      end else if (accept && kind == KIND_QUERY) begin
        pick_lfsr <= lfsr_step(pick_lfsr);
      end
      // saturating item counter
      if (accept && event_count != COUNT_MAX) begin
        event_count <= event_count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/nvs_back.sv =====
// back end: set row memory, read-modify-write of stamps and victim selection
`default_nettype none

module nvs_back import nvs_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    mid_empty,
  output logic                                         mid_pop,
  input  wire kind_t                                   mid_kind,
  input  wire logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] mid_set,
  input  wire logic [$clog2(WAYS)-1:0]                 mid_way,
  input  wire logic [STAMP_W-1:0]                      mid_stamp,
  input  wire logic [LFSR_W-1:0]                       mid_rnd,
  input  wire logic                                    out_full,
  output logic                                         out_push,
  output out_item_t                                    out_item,
  output logic                                         clearing
);

  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = $clog2(WAYS);
  localparam int PAD      = 1 << WAY_W;
  localparam int MOD_M    = WAYS - 1;
  localparam int RECIP_SH = 20;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = LFSR_W + RECIP_W;
  localparam int Q_W      = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / MOD_M);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READ,
    S_EXEC
  } state_t;

  state_t state;

  logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SETS];
  logic [WAYS-1:0]              valid_mem [SETS];
  logic [WAYS-1:0][STAMP_W-1:0] rd_stamps;
  logic [WAYS-1:0]              rd_valids;
  logic [WAYS-1:0][STAMP_W-1:0] wr_stamps;
  logic [WAYS-1:0]              wr_valids;

  logic [SET_W-1:0]   clr_addr;
  logic [SET_W-1:0]   mem_addr;
  logic               mem_we;
  logic               mem_re;

  kind_t              cur_kind;
  logic [SET_W-1:0]   cur_set;
  logic [WAY_W-1:0]   cur_way;
  logic [STAMP_W-1:0] cur_stamp;
  logic [LFSR_W-1:0]  cur_rnd;
  logic [PROD_W-1:0]  prod;

  logic               is_update;
  logic               finish;

  logic [STAMP_W-1:0] node_stamp [WAY_W+1][PAD];
  logic [WAY_W-1:0]   node_idx   [WAY_W+1][PAD];
  logic [WAY_W-1:0]   mru;

  logic [Q_W-1:0]     q_est;
  logic [Q_W-1:0]     r_raw;
  logic [Q_W-1:0]     r_fix;
  logic [WAY_W-1:0]   r_sel;
  logic [WAY_W-1:0]   pick;
  logic [WAY_W-1:0]   inv_idx;
  logic               any_inv;
  logic [WAY_W-1:0]   final_way;

  assign clearing  = (state == S_CLEAR);
  assign mid_pop   = (state == S_READ) & ~mid_empty;
  assign is_update = (cur_kind == KIND_TOUCH) || (cur_kind == KIND_INSERT) ||
                     (cur_kind == KIND_INVAL);
  assign finish    = (state == S_EXEC) & ~out_full;
  assign out_push  = finish;
  assign mem_re    = mid_pop;
  assign mem_we    = clearing | (finish & is_update);

  always_comb begin
    case (state)
      S_CLEAR: mem_addr = clr_addr;
      S_READ:  mem_addr = mid_set;
      default: mem_addr = cur_set;
    endcase
  end

  // row write-back data
  always_comb begin
    wr_stamps = rd_stamps;
    wr_valids = rd_valids;
    if (clearing) begin
      wr_stamps = '0;
      wr_valids = '0;
    end else begin
      case (cur_kind)
        KIND_TOUCH: begin
          wr_stamps[cur_way] = cur_stamp;
        end
        KIND_INSERT: begin
          wr_stamps[cur_way] = cur_stamp;
          wr_valids[cur_way] = 1'b1;
        end
        KIND_INVAL: begin
          wr_stamps[cur_way] = '0;
          wr_valids[cur_way] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stamp_mem[mem_addr] <= wr_stamps;
      valid_mem[mem_addr] <= wr_valids;
    end
    if (mem_re) begin
      rd_stamps <= stamp_mem[mem_addr];
      rd_valids <= valid_mem[mem_addr];
    end
  end

  // max-stamp tree, the left (lower) side wins ties
  always_comb begin
    for (int l = 0; l <= WAY_W; l++) begin
      for (int n = 0; n < PAD; n++) begin
        node_stamp[l][n] = '0;
        node_idx[l][n]   = '0;
      end
    end
    for (int n = 0; n < PAD; n++) begin
      node_idx[0][n] = WAY_W'(n);
      if (n < WAYS) begin
        node_stamp[0][n] = rd_stamps[n];
      end
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int n = 0; n < (PAD >> (l + 1)); n++) begin
        if (node_stamp[l][2*n+1] > node_stamp[l][2*n]) begin
          node_stamp[l+1][n] = node_stamp[l][2*n+1];
          node_idx[l+1][n]   = node_idx[l][2*n+1];
        end else begin
          node_stamp[l+1][n] = node_stamp[l][2*n];
          node_idx[l+1][n]   = node_idx[l][2*n];
        end
      end
    end
  end

  assign mru = node_idx[WAY_W][0];

  // random value modulo ways-1 by reciprocal, one correction step
  assign q_est = prod[PROD_W-1:RECIP_SH];
  assign r_raw = Q_W'(cur_rnd) - Q_W'(q_est * Q_W'(MOD_M));
  assign r_fix = (r_raw >= Q_W'(MOD_M)) ? r_raw - Q_W'(MOD_M) : r_raw;
  assign r_sel = WAY_W'(r_fix);
  assign pick  = (r_sel < mru) ? r_sel : WAY_W'(r_sel + 1'b1);

  // first invalid way
  always_comb begin
    inv_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!rd_valids[i]) begin
        inv_idx = WAY_W'(i);
      end
    end
  end

  assign any_inv   = ~(&rd_valids);
  assign final_way = any_inv ? inv_idx : pick;

  always_comb begin
    out_item = '0;
    if (cur_kind == KIND_QUERY) begin
      out_item.is_victim          = 1'b1;
      out_item.victim_way         = WAYIDX_W'(final_way);
      out_item.victim_was_invalid = any_inv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == SET_W'(SETS - 1)) begin
            state <= S_READ;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_READ: begin
          if (!mid_empty) begin
            cur_kind  <= mid_kind;
            cur_set   <= mid_set;
            cur_way   <= mid_way;
            cur_stamp <= mid_stamp;
            cur_rnd   <= mid_rnd;
            prod      <= PROD_W'(mid_rnd) * PROD_W'(RECIP);
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!out_full) begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/nmru_victim_select.sv =====
// Not-most-recently-used victim selection for a set-associative cache.
// Input channel: request (op, set_index, way_index) is taken on a clock edge
// with push high and full low. Result channel: while empty is low the oldest
// result sits on result and leaves on a clock edge with pop high.
// Every item gives exactly one result; only victim queries set is_victim.
// Configuration: cfg_we with cfg_data loads the 16-bit generator seed and
// restarts the generator at once; write it only while the block is idle.
// The back end handles one item at a time: the single-port set row memory
// is read in S_READ and written back in S_EXEC, which waits while the
// result queue is full; the work queue keeps taking items meanwhile.
// Reset: the row memory is cleared one set per cycle, with full held high;
// configuration writes are still taken.
// When pop stays low, the 2-entry result queue and then the 4-entry work
// queue fill, and full rises; nothing is dropped.
`default_nettype none

`include "nmru_victim_select_defines.svh"

module nmru_victim_select import nvs_pkg::*; #(
  parameter int WAYS = 8,
  parameter int SETS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire in_item_t          request,
  input  wire logic              push,
  output logic                   full,
  output out_item_t              result,
  output logic                   empty,
  input  wire logic              pop,
  input  wire logic              cfg_we,
  input  wire logic [LFSR_W-1:0] cfg_data
);

  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = $clog2(WAYS);
  localparam int KIND_W    = $bits(kind_t);
  localparam int MID_W     = KIND_W + SET_W + WAY_W + STAMP_W + LFSR_W;
  localparam int OUT_W     = $bits(out_item_t);
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  logic               mid_push;
  logic               mid_pop;
  logic               mid_full;
  logic               mid_empty;
  kind_t              f_kind;
  logic [SET_W-1:0]   f_set;
  logic [WAY_W-1:0]   f_way;
  logic [STAMP_W-1:0] f_stamp;
  logic [LFSR_W-1:0]  f_rnd;
  logic [MID_W-1:0]   mid_wdata;
  logic [MID_W-1:0]   mid_rdata;
  kind_t              b_kind;
  logic [SET_W-1:0]   b_set;
  logic [WAY_W-1:0]   b_way;
  logic [STAMP_W-1:0] b_stamp;
  logic [LFSR_W-1:0]  b_rnd;
  logic               clearing;
  logic               out_push;
  logic               out_full;
  out_item_t          out_item;
  logic [OUT_W-1:0]   out_rdata;

  nvs_front #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .push      (push),
    .full      (full),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mid_full  (mid_full),
    .clearing  (clearing),
    .mid_push  (mid_push),
    .mid_kind  (f_kind),
    .mid_set   (f_set),
    .mid_way   (f_way),
    .mid_stamp (f_stamp),
    .mid_rnd   (f_rnd)
  );

  assign mid_wdata = {f_kind, f_set, f_way, f_stamp, f_rnd};

  nvs_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wdata),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  assign b_kind  = kind_t'(mid_rdata[MID_W-1 -: KIND_W]);
  assign b_set   = mid_rdata[MID_W-KIND_W-1 -: SET_W];
  assign b_way   = mid_rdata[STAMP_W+LFSR_W+WAY_W-1 -: WAY_W];
  assign b_stamp = mid_rdata[STAMP_W+LFSR_W-1 -: STAMP_W];
  assign b_rnd   = mid_rdata[LFSR_W-1:0];

  nvs_back #(
    .WAYS (WAYS),
    .SETS (SETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_kind  (b_kind),
    .mid_set   (b_set),
    .mid_way   (b_way),
    .mid_stamp (b_stamp),
    .mid_rnd   (b_rnd),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item),
    .clearing  (clearing)
  );

  nvs_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_item),
    .rd_en   (pop),
    .rd_data (out_rdata),
    .full    (out_full),
    .empty   (empty)
  );

  assign result = out_item_t'(out_rdata);

  `NVS_ASSERT_IMPL(a_full_while_clearing, clearing, full)
  `NVS_ASSERT_IMPL(a_mid_no_overflow, mid_push, !mid_full)
  `NVS_ASSERT_IMPL(a_out_no_overflow, out_push, !out_full)
  `NVS_ASSERT_IMPL(a_plain_result_zero, !empty && !result.is_victim, (result.victim_way == '0) && !result.victim_was_invalid)
  `NVS_ASSERT_NEXT(a_pop_follows_read, mid_pop, !mid_pop)

endmodule

`default_nettype wire

// ===== tb/nmru_victim_select_test.sv =====
// testbench for the nmru victim select block: directed and random cache traffic checked against a predictor
`timescale 1ns / 100ps

module nmru_victim_select_test;
  import nvs_pkg::*;

  localparam int WAYS = 8;
  localparam int SETS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t request = '0;
  logic push = 1'b0;
  logic full;
  out_item_t result;
  logic empty;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [LFSR_W-1:0] cfg_data = '0;

  nmru_victim_select #(.WAYS(WAYS), .SETS(SETS)) u_dut (
    .clk(clk),
    .rst(rst),
    .request(request),
    .push(push),
    .full(full),
    .result(result),
    .empty(empty),
    .pop(pop),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // predicted replacement state
  logic [STAMP_W-1:0] stamp_mem [SETS*WAYS];
  logic valid_mem [SETS*WAYS];
  logic [STAMP_W-1:0] event_ctr = COUNT_RESET;
  logic [LFSR_W-1:0] pick_gen = SEED_DEFAULT;

  in_item_t requests_waiting[$];
  out_item_t answers_due[$];

  bit calm = 1'b1;
  int send_gap = 0;
  int pop_gap = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_taken = 0;
  int results_seen = 0;
  int full_stalls = 0;
  int queries = 0;
  int invalid_picks = 0;
  int seeds_loaded = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout: run did not finish, %0d results outstanding", answers_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic out_item_t nmru_predict(in_item_t it);
    int base;
    int mru;
    int r;
    int pick;
    bit found;
    logic [STAMP_W-1:0] best;
    out_item_t ans;
    base = (int'(it.set_index) % SETS) * WAYS;
    ans = '0;
    if (it.op == OP_QUERY) begin
      mru = 0;
      best = stamp_mem[base];
      for (int i = 1; i < WAYS; i++) begin
        if (stamp_mem[base+i] > best) begin
          best = stamp_mem[base+i];
          mru = i;
        end
      end
      // random pick among the ways other than the most recent one
      r = int'(pick_gen) % (WAYS - 1);
      pick = (r < mru) ? r : r + 1;
      pick_gen = (pick_gen >> 1) ^ (pick_gen[0] ? LFSR_TAPS : '0);
      found = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!found && !valid_mem[base+i]) begin
          pick = i;
          found = 1'b1;
        end
      end
      ans.is_victim = 1'b1;
      ans.victim_way = WAYIDX_W'(pick);
      ans.victim_was_invalid = found;
      queries++;
      if (found) invalid_picks++;
    end else if (int'(it.way_index) < WAYS) begin
      case (it.op)
        OP_TOUCH: begin
          stamp_mem[base+it.way_index] = event_ctr;
        end
        OP_INSERT: begin
          stamp_mem[base+it.way_index] = event_ctr;
          valid_mem[base+it.way_index] = 1'b1;
        end
        default: begin
          stamp_mem[base+it.way_index] = '0;
          valid_mem[base+it.way_index] = 1'b0;
        end
      endcase
    end
    if (event_ctr != COUNT_MAX) event_ctr++;
    return ans;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t ns, result %0d: %s got %0d want %0d",
               $time, results_seen, what, got, want);
    end
  endtask

  // sender: one item per handshake, random gaps between items
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && full) full_stalls++;
      if (push && !full) begin
        answers_due.push_back(nmru_predict(request));
        items_taken++;
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (requests_waiting.size() != 0) begin
          request <= requests_waiting.pop_front();
          push <= 1'b1;
          send_gap = calm ? 0 : gap_len();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result, stalls at random and twice for a long stretch
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          flag_mismatch("result with nothing pending, is_victim", result.is_victim, 0);
        end else begin
          want = answers_due.pop_front();
          if (result.is_victim !== want.is_victim)
            flag_mismatch("is_victim", result.is_victim, want.is_victim);
          if (result.victim_way !== want.victim_way)
            flag_mismatch("victim_way", result.victim_way, want.victim_way);
          if (result.victim_was_invalid !== want.victim_was_invalid)
            flag_mismatch("victim_was_invalid", result.victim_was_invalid,
                          want.victim_was_invalid);
        end
        if (results_seen == 300 || results_seen == 900) hold_left = 100;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) pop_gap = gap_len();
      end
    end
  end

  task automatic add_item(logic [OP_W-1:0] op, int set, int way);
    in_item_t it;
    it.op = op;
    it.set_index = SETIDX_W'(set);
    it.way_index = WAYIDX_W'(way);
    requests_waiting.push_back(it);
  endtask

  // waits until nothing is queued, offered or outstanding
  task automatic drain();
    do @(negedge clk);
    while (requests_waiting.size() != 0 || push || answers_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_seed(logic [LFSR_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    pick_gen = (v == '0) ? SEED_DEFAULT : v;
    seeds_loaded++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_directed();
    // empty set: first invalid way wins
    add_item(OP_QUERY, 0, 7);
    for (int w = 0; w < WAYS; w++) add_item(OP_INSERT, 63, w);
    // full set, most recent is the last way
    add_item(OP_QUERY, 63, 0);
    add_item(OP_TOUCH, 63, 0);
    add_item(OP_QUERY, 63, 7);
    add_item(OP_TOUCH, 63, 7);
    add_item(OP_QUERY, 63, 3);
    // a hole in the middle of a full set overrides the random pick
    add_item(OP_INVAL, 63, 4);
    add_item(OP_QUERY, 63, 0);
    add_item(OP_INSERT, 63, 4);
    add_item(OP_QUERY, 63, 5);
    // touch alone does not make a way valid
    add_item(OP_TOUCH, 0, 7);
    add_item(OP_QUERY, 0, 0);
    add_item(OP_INSERT, 0, 0);
    add_item(OP_INVAL, 0, 0);
    add_item(OP_QUERY, 0, 2);
  endtask

  task automatic queue_random(int target);
    int added;
    int set;
    int r;
    int j;
    int n;
    logic [WAYIDX_W-1:0] order [WAYS];
    logic [WAYIDX_W-1:0] tmp;
    logic [OP_W-1:0] op;
    added = 0;
    while (added < target) begin
      set = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, SETS - 1);
      if ($urandom_range(0, 4) == 0) begin
        // fill a whole set in random order, touch a few ways, then query
        for (int i = 0; i < WAYS; i++) order[i] = WAYIDX_W'(i);
        for (int i = WAYS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < WAYS; i++) add_item(OP_INSERT, set, order[i]);
        added += WAYS;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) add_item(OP_TOUCH, set, $urandom_range(0, WAYS - 1));
        added += n;
        n = $urandom_range(2, 5);
        for (int i = 0; i < n; i++) add_item(OP_QUERY, set, $urandom_range(0, WAYS - 1));
        added += n;
      end else begin
        r = $urandom_range(0, 99);
        op = (r < 25) ? OP_TOUCH : (r < 55) ? OP_INSERT : (r < 67) ? OP_INVAL : OP_QUERY;
        add_item(op, set, $urandom_range(0, WAYS - 1));
        added++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SETS * WAYS; i++) begin
      stamp_mem[i] = '0;
      valid_mem[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed();
    drain();
    load_seed(16'hFFFF);
    calm = 1'b0;
    queue_random(450);
    load_seed(16'h0000);
    queue_random(300);
    load_seed(LFSR_W'($urandom_range(2, 16'hFFFE)));
    queue_random(300);
    load_seed(16'h0001);
    queue_random(300);
    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d items over %0d seed settings: %0d victim queries, %0d invalid picks",
             items_taken, seeds_loaded, queries, invalid_picks);
    $display("input held off by a full block on %0d cycles", full_stalls);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
